// ----- hdl/utf8_decoder_raw_fallback_macros.svh -----
// Assertion macros shared by the UTF-8 decoder RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef UTF8_DECODER_RAW_FALLBACK_MACROS_SVH
`define UTF8_DECODER_RAW_FALLBACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/utf8d_pkg.sv -----
// Types and constants of the UTF-8 decoder with raw fallback.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int HELD_DEPTH = 4;
    localparam int HELD_IDX_W = 2;
    localparam int CNT_W      = 3;
    localparam int QDEPTH     = 2;

    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] KEEP4_MASK  = 8'h07;
    localparam logic [BYTE_W-1:0] KEEP3_MASK  = 8'h0f;
    localparam logic [BYTE_W-1:0] KEEP2_MASK  = 8'h1f;
    localparam logic [BYTE_W-1:0] FOLLOW_MASK = 8'h3f;
    localparam logic [BYTE_W-1:0] FOLLOW_FLAG = 8'h80;

    typedef logic [HELD_DEPTH-1:0][BYTE_W-1:0] held_arr_t;

    // One unit of output work: a decoded code point, or a raw flush of held bytes.
    typedef struct packed {
        logic               raw;
        logic [CP_W-1:0]    cp;
        held_arr_t          bytes;
        logic [CNT_W-1:0]   cnt;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- hdl/utf8d_front.sv -----
// Front end: accepts bytes, tracks the open sequence and issues output jobs.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_front
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_text,
    input  q_stat_t           q_stat,
    output logic              push,
    output job_t              push_job
);

    logic [1:0]       remain_reg, remain_next;
    logic [CP_W-1:0]  accum_reg, accum_next;
    logic             ok_reg, ok_next;
    logic [CNT_W-1:0] count_reg, count_next;
    held_arr_t        held_reg, held_next;
    logic             accept;
    logic             emit;
    logic             follow_ok;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && emit;
    assign follow_ok = ok_reg && ((in_byte & FOLLOW_FLAG) != '0);

    always_comb
    begin
        remain_next = remain_reg;
        accum_next  = accum_reg;
        ok_next     = ok_reg;
        count_next  = count_reg;
        held_next   = held_reg;
        emit        = 1'b0;
        push_job.raw   = 1'b0;
        push_job.cp    = {{(CP_W-BYTE_W){1'b0}}, in_byte};
        push_job.bytes = held_reg;
        push_job.cnt   = CNT_W'(1);
        if (remain_reg == 2'd0)
        begin
            held_next[0] = in_byte;
            count_next   = CNT_W'(1);
            ok_next      = 1'b1;
            priority if ((in_byte & LEAD4_MASK) == LEAD4_MASK)
            begin
                remain_next = 2'd3;
                accum_next  = CP_W'(in_byte & KEEP4_MASK);
            end
            else if ((in_byte & LEAD3_MASK) == LEAD3_MASK)
            begin
                remain_next = 2'd2;
                accum_next  = CP_W'(in_byte & KEEP3_MASK);
            end
            else if ((in_byte & LEAD2_MASK) == LEAD2_MASK)
            begin
                remain_next = 2'd1;
                accum_next  = CP_W'(in_byte & KEEP2_MASK);
            end
            else
            begin
                // plain byte or stray continuation: pass through
                emit        = 1'b1;
                held_next   = held_reg;
                count_next  = count_reg;
            end
            if (remain_next != 2'd0 && end_of_text)
            begin
                // lone lead at end of text: flush it raw
                emit           = 1'b1;
                push_job.raw   = 1'b1;
                push_job.bytes = held_next;
                push_job.cnt   = CNT_W'(1);
            end
        end
        else
        begin
            held_next[count_reg[HELD_IDX_W-1:0]] = in_byte;
            count_next  = count_reg + CNT_W'(1);
            remain_next = remain_reg - 2'd1;
            ok_next     = follow_ok;
            if (follow_ok)
            begin
                accum_next = {accum_reg[CP_W-7:0], in_byte[5:0]};
            end
            push_job.bytes = held_next;
            push_job.cnt   = count_next;
            if (remain_next == 2'd0)
            begin
                emit = 1'b1;
                if (follow_ok)
                begin
                    push_job.cp  = accum_next;
                    push_job.cnt = CNT_W'(1);
                end
                else
                begin
                    push_job.raw = 1'b1;
                end
            end
            else if (end_of_text)
            begin
                emit         = 1'b1;
                push_job.raw = 1'b1;
            end
        end
        // any emitted job closes the sequence
        if (emit)
        begin
            remain_next = 2'd0;
            accum_next  = '0;
            ok_next     = 1'b1;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 2'd0;
            accum_reg  <= '0;
            ok_reg     <= 1'b1;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            remain_reg <= remain_next;
            accum_reg  <= accum_next;
            ok_reg     <= ok_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- hdl/utf8d_fifo.sv -----
// Short job queue between the front end and the output sequencer.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_fifo
    import utf8d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t stat
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    job_t              slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;

    assign head       = slot_reg[rd_reg];
    assign stat.full  = (fill_reg == CNT_QW'(QDEPTH));
    assign stat.empty = (fill_reg == '0);

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + CNT_QW'(1);
            2'b01:   fill_next = fill_reg - CNT_QW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/utf8d_back.sv -----
// Output sequencer: walks each queued job and drives one registered word per cycle unless stalled.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_back
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  job_t            head,
    input  q_stat_t         q_stat,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [CP_W-1:0] code_point,
    output logic            is_raw,
    output logic            last_of_run
);

    logic [HELD_IDX_W-1:0] idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [CP_W-1:0]       cp_reg, cp_next;
    logic                  raw_reg, raw_next;
    logic                  last_reg, last_next;
    logic                  load;
    logic                  item_last;

    assign load      = !q_stat.empty && (!valid_reg || !out_stall);
    assign item_last = ({1'b0, idx_reg} == head.cnt - CNT_W'(1));
    assign pop       = load && item_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        cp_next    = cp_reg;
        raw_next   = raw_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            raw_next   = head.raw;
            last_next  = item_last;
            cp_next    = head.raw ? {{(CP_W-BYTE_W){1'b0}}, head.bytes[idx_reg]} : head.cp;
            // advance within the job, rewind when it is done
            idx_next   = item_last ? '0 : idx_reg + HELD_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        raw_reg  <= raw_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign code_point  = cp_reg;
    assign is_raw      = raw_reg;
    assign last_of_run = last_reg;

endmodule

// ----- hdl/utf8_decoder_raw_fallback.sv -----
// UTF-8 decoder with raw fallback: one byte in per cycle unless in_stall, code points or raw bytes out.
// Jobs are written into the job queue, and each output word is registered in the sequencer.
// Throughput: 1 byte per cycle while the queue has room; a failed sequence of k bytes is flushed as
// k raw words, which the two-entry job queue absorbs until it fills.
// Reset (rst_n, async, low): no open sequence, queue empty, no output valid.
`timescale 1ns / 1ps
`include "utf8_decoder_raw_fallback_macros.svh"

module utf8_decoder_raw_fallback
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_text,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CP_W-1:0]   code_point,
    output logic              is_raw,
    output logic              last_of_run
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head;

    utf8d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job)
    );

    utf8d_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .is_raw      (is_raw),
        .last_of_run (last_of_run)
    );

    `UTF8D_ASSERT_NOW(a_cp_single, clk, rst_n, out_valid && !is_raw, last_of_run, "decoded word not last of run")
    `UTF8D_ASSERT_NOW(a_raw_byte, clk, rst_n, out_valid && is_raw, code_point[CP_W-1:BYTE_W] == '0, "raw word above one byte")
    `UTF8D_ASSERT_NOW(a_stall_full, clk, rst_n, !q_stat.full, !in_stall, "input stalled with queue room")
    `UTF8D_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !q_stat.empty, "pushed job lost from queue")

endmodule

// ----- tb/utf8_decoder_raw_fallback_checker.sv -----
// Scoreboard for the UTF-8 decoder: watches both channels, predicts every output word
// from the accepted bytes and compares them field by field. Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8_decoder_raw_fallback_checker
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_text,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CP_W-1:0]   code_point,
    input  logic              is_raw,
    input  logic              last_of_run,
    output int                fail_count,
    output int                pending_words
);

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            raw;
        logic            last;
    } cp_word_t;

    cp_word_t expected_cps[$];

    // Decoder state as seen by the predictor
    logic [1:0]        follow_left;
    logic [CP_W-1:0]   cp_accum;
    logic              seq_ok;
    logic [BYTE_W-1:0] held [HELD_DEPTH];
    logic [CNT_W-1:0]  held_n;

    task automatic clear_open_seq();
        follow_left = '0;
        cp_accum    = '0;
        seq_ok      = 1'b1;
        held_n      = '0;
    endtask

    task automatic push_cp(input logic [CP_W-1:0] cp, input logic raw);
        cp_word_t w;
        w.cp   = cp;
        w.raw  = raw;
        w.last = 1'b0;
        expected_cps.insert(expected_cps.size(), w);
    endtask

    task automatic flush_held();
        for (int i = 0; i < held_n && i < HELD_DEPTH; i++)
            push_cp(CP_W'(held[i]), 1'b1);
        clear_open_seq();
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
        int       n_before;
        cp_word_t tail;
        n_before = expected_cps.size();
        if (follow_left == 0) begin
            if ((b & LEAD4_MASK) == LEAD4_MASK) begin
                follow_left = 2'd3;
                cp_accum    = CP_W'(b & KEEP4_MASK);
            end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
                follow_left = 2'd2;
                cp_accum    = CP_W'(b & KEEP3_MASK);
            end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
                follow_left = 2'd1;
                cp_accum    = CP_W'(b & KEEP2_MASK);
            end else begin
                // plain byte or stray continuation: pass through
                push_cp(CP_W'(b), 1'b0);
            end
            if (follow_left != 0) begin
                seq_ok  = 1'b1;
                held[0] = b;
                held_n  = 1;
                if (eot)
                    flush_held();
            end
        end else begin
            held[held_n[1:0]] = b;
            held_n = held_n + 1'b1;
            if (seq_ok && (b & FOLLOW_FLAG) != 0)
                cp_accum = (cp_accum << 6) | CP_W'(b & FOLLOW_MASK);
            else
                seq_ok = 1'b0;
            follow_left = follow_left - 1'b1;
            if (follow_left == 0) begin
                if (seq_ok) begin
                    push_cp(cp_accum, 1'b0);
                    clear_open_seq();
                end else begin
                    flush_held();
                end
            end else if (eot) begin
                flush_held();
            end
        end
        // mark the final word caused by this byte
        if (expected_cps.size() > n_before) begin
            tail = expected_cps[expected_cps.size() - 1];
            tail.last = 1'b1;
            expected_cps[expected_cps.size() - 1] = tail;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        cp_word_t want;
        if (!rst_n) begin
            clear_open_seq();
            for (int i = 0; i < HELD_DEPTH; i++)
                held[i] = '0;
            expected_cps.delete();
            fail_count = 0;
            pending_words <= 0;
        end else begin
            if (in_valid && !in_stall)
                decode_byte(in_byte, end_of_text);
            if (out_valid && !out_stall) begin
                if (expected_cps.size() == 0) begin
                    $error("unexpected word: code_point %h is_raw %b last_of_run %b",
                           code_point, is_raw, last_of_run);
                    fail_count++;
                end else begin
                    want = expected_cps.pop_front();
                    if (code_point !== want.cp) begin
                        $error("code_point: expected %h, got %h", want.cp, code_point);
                        fail_count++;
                    end
                    if (is_raw !== want.raw) begin
                        $error("is_raw: expected %b, got %b", want.raw, is_raw);
                        fail_count++;
                    end
                    if (last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, last_of_run);
                        fail_count++;
                    end
                end
            end
            pending_words <= expected_cps.size();
        end
    end

endmodule

// ----- tb/utf8_decoder_raw_fallback_tb.sv -----
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and output stalls.
// Depends on utf8d_pkg, the decoder RTL and utf8_decoder_raw_fallback_checker.
`timescale 1ns / 1ps

module utf8_decoder_raw_fallback_tb
    import utf8d_pkg::*;
();

    localparam int RANDOM_BYTES = 370;
    localparam int CALM_AFTER   = 310;
    localparam int DRAIN_AT     = 150;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        SEQ_ASCII,
        SEQ_NOISE,
        SEQ_LEAD2,
        SEQ_LEAD3,
        SEQ_LEAD4
    } seq_kind_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_text;
    logic              out_valid;
    logic              out_stall;
    logic [CP_W-1:0]   code_point;
    logic              is_raw;
    logic              last_of_run;

    int fail_count;
    int pending_words;
    int random_bytes;
    int cycle_count;
    bit calm;

    utf8_decoder_raw_fallback i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .is_raw      (is_raw),
        .last_of_run (last_of_run)
    );

    utf8_decoder_raw_fallback_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .is_raw        (is_raw),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Output side: stall bursts alternating with free-running stretches
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm || $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Present one word and hold it until accepted; sometimes idle first
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    // One random sequence: mostly multi-byte code points, some broken or cut off
    task automatic send_random_seq();
        seq_kind_t         kind;
        int                pick;
        int                n_follow;
        logic [BYTE_W-1:0] b;
        logic              eot;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            kind = SEQ_ASCII;
        else if (pick == 2)
            kind = SEQ_NOISE;
        else if (pick < 5)
            kind = SEQ_LEAD2;
        else if (pick < 7)
            kind = SEQ_LEAD3;
        else
            kind = SEQ_LEAD4;

        case (kind)
            SEQ_ASCII:
            begin
                send_byte({1'b0, 7'($urandom_range(0, 127))}, $urandom_range(0, 7) == 0);
                random_bytes++;
                return;
            end
            SEQ_NOISE:
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                random_bytes++;
                return;
            end
            SEQ_LEAD2:
            begin
                b = {3'b110, 5'($urandom_range(0, 31))};
                n_follow = 1;
            end
            SEQ_LEAD3:
            begin
                b = {4'b1110, 4'($urandom_range(0, 15))};
                n_follow = 2;
            end
            default:
            begin
                // includes the five-bit and longer leads 0xF8..0xFF
                b = {4'b1111, 4'($urandom_range(0, 15))};
                n_follow = 3;
            end
        endcase

        eot = ($urandom_range(0, 14) == 0);
        send_byte(b, eot);
        random_bytes++;
        if (eot)
            return;
        for (int i = 0; i < n_follow; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                b = {1'b0, 7'($urandom_range(0, 127))};
            else if (pick < 4)
                b = {2'b11, 6'($urandom_range(0, 63))};
            else
                b = {2'b10, 6'($urandom_range(0, 63))};
            if (i == n_follow - 1)
                eot = ($urandom_range(0, 7) == 0);
            else
                eot = ($urandom_range(0, 14) == 0);
            send_byte(b, eot);
            random_bytes++;
            if (eot)
                return;
        end
    endtask

    initial
    begin
        bit drained;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = '0;
        end_of_text  = 1'b0;
        calm         = 1'b0;
        random_bytes = 0;
        drained      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of plain bytes and stray continuations
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hbf, 1'b0);
        // well-formed two, three and four byte forms
        send_byte(8'hc2, 1'b0);
        send_byte(8'ha9, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hac, 1'b1);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // top of the range through an over-long lead and loose follow bytes
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hff, 1'b0);
        // failed follow byte: the rest is still consumed, all flushed raw
        send_byte(8'he2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hc2, 1'b0);
        // lone lead cut off, then a sequence cut off midway
        send_byte(8'hdf, 1'b1);
        send_byte(8'hf7, 1'b0);
        send_byte(8'hbf, 1'b1);

        while (random_bytes < RANDOM_BYTES)
        begin
            if (!drained && random_bytes >= DRAIN_AT)
            begin
                // hold off until every expected word has come out
                wait_drained();
                drained = 1'b1;
            end
            if (random_bytes >= CALM_AFTER)
                calm = 1'b1;
            send_random_seq();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
